@@ rtl/core/mts_pkg.sv @@
package mts_pkg;

    localparam logic [1:0] MODE_ADVANCE = 2'd0;
    localparam logic [1:0] MODE_ONESHOT = 2'd1;
    localparam logic [1:0] MODE_REPEAT  = 2'd2;
    localparam logic [1:0] MODE_CANCEL  = 2'd3;

    localparam logic [1:0] KIND_ID      = 2'd0;
    localparam logic [1:0] KIND_TIMEOUT = 2'd1;
    localparam logic [1:0] KIND_FULL    = 2'd2;

    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 24;
    localparam int ID_W     = 16;
    localparam int DEST_W   = 8;
    localparam int COUNT_W  = 16;

    // quotient of a 31-bit difference by a 24-bit period
    localparam int QUOT_W   = 31;

    // one slot's stored contents
    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [DEST_W-1:0]   dest;
        logic [TIME_W-1:0]   deadline;
        logic [PERIOD_W-1:0] period;
        logic                repeating;
    } slot_t;

    // divider control and status
    typedef struct packed {
        logic                start;
        logic [QUOT_W-1:0]   dividend;
        logic [PERIOD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [QUOT_W-1:0]   quot;
        logic [PERIOD_W-1:0] rem;
    } div_rsp_t;

endpackage

@@ rtl/core/mts_ram.sv @@
module mts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/mts_div.sv @@
module mts_div
    import mts_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [QUOT_W-1:0]   quot_reg, quot_next;
    logic [PERIOD_W-1:0] rem_reg, rem_next;
    logic [PERIOD_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [PERIOD_W:0]   trial;

    // restoring division, one quotient bit a cycle
    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quot_reg[QUOT_W-1]};
        if (req.start) begin
            quot_next = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = CNT_W'(QUOT_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next  = PERIOD_W'(trial - {1'b0, dvs_reg});
                quot_next = {quot_reg[QUOT_W-2:0], 1'b1};
            end else begin
                rem_next  = trial[PERIOD_W-1:0];
                quot_next = {quot_reg[QUOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

@@ rtl/core/multi_timer_service.sv @@
// Channel | Ports                                          | Direction
// request | s_valid s_ready s_mode s_elapsed s_delay        | in
//         | s_dest_id s_cancel_id                          |
// result  | m_valid m_ready m_kind m_timer_id m_notify_dest| out
//         | m_timeout_count m_last                         |
//
// One request is taken at a time; a start passes through ST_START and ST_WAIT first.
// The slots are then visited one by one through the slot RAM in ST_READ, ST_EVAL
// and ST_EMIT, with the shared serial divider run for each expired repeating slot;
// the scan stalls while a result is held with m_ready low.
// Reset clears the valid bits, the clock and the id counter; no clearing pass.
module multi_timer_service
    import mts_pkg::*;
#(
    parameter int MAX_TIMERS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_mode,
    input  logic [15:0]         s_elapsed,
    input  logic [23:0]         s_delay,
    input  logic [7:0]          s_dest_id,
    input  logic [15:0]         s_cancel_id,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_kind,
    output logic [15:0]         m_timer_id,
    output logic [7:0]          m_notify_dest,
    output logic [15:0]         m_timeout_count,
    output logic                m_last
);

    localparam int IDX_W  = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int SLOT_W = $bits(slot_t);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_EVAL  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;
    localparam logic [2:0] ST_WAIT  = 3'd5;
    localparam logic [2:0] ST_START = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [MAX_TIMERS-1:0] valid_reg, valid_next;
    logic [TIME_W-1:0]     time_reg, time_next;
    logic [ID_W-1:0]       nid_reg, nid_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [1:0]            mode_reg, mode_next;
    logic [PERIOD_W-1:0]   dly_reg, dly_next;
    logic [DEST_W-1:0]     dst_reg, dst_next;
    logic [ID_W-1:0]       cid_reg, cid_next;
    logic [IDX_W-1:0]      free_reg, free_next;
    logic                  full_reg, full_next;
    logic [TIME_W-1:0]     diff_reg, diff_next;

    // pending result held until the next one is known (to mark last)
    logic                  pend_reg, pend_next;
    logic [1:0]            pk_reg, pk_next;
    logic [ID_W-1:0]       pid_reg, pid_next;
    logic [DEST_W-1:0]     pdst_reg, pdst_next;
    logic [COUNT_W-1:0]    pcnt_reg, pcnt_next;

    // output register
    logic                  ov_reg, ov_next;
    logic [1:0]            ok_reg, ok_next;
    logic [ID_W-1:0]       oid_reg, oid_next;
    logic [DEST_W-1:0]     odst_reg, odst_next;
    logic [COUNT_W-1:0]    ocnt_reg, ocnt_next;
    logic                  olast_reg, olast_next;

    logic                  we;
    logic [IDX_W-1:0]      waddr;
    slot_t                 wdata, rdata;
    logic [SLOT_W-1:0]     rdata_raw;
    div_req_t              dreq;
    div_rsp_t              drsp;

    logic [TIME_W-1:0]     new_deadline;
    logic [QUOT_W:0]       count_full;
    logic [TIME_W-1:0]     advance;
    logic                  push;
    logic [1:0]            push_k;
    logic [ID_W-1:0]       push_id;
    logic [DEST_W-1:0]     push_dst;
    logic [COUNT_W-1:0]    push_cnt;
    logic                  flush;
    logic                  out_free;
    logic [PERIOD_W-1:0]   dly_fix;

    mts_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_TIMERS)) u_slots (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (idx_reg),
        .rdata (rdata_raw)
    );
    assign rdata = slot_t'(rdata_raw);

    mts_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    assign out_free = !ov_reg || m_ready;
    assign dly_fix  = (s_delay == '0) ? PERIOD_W'(1) : s_delay;
    assign count_full = {1'b0, drsp.quot} + 1'b1;
    // deadline moves by (q+1)*period = diff - rem + period
    assign advance = diff_reg - TIME_W'(drsp.rem) + TIME_W'(rdata.period);
    assign new_deadline = rdata.deadline + advance;

    // sequencer
    always_comb begin
        state_next = state_reg;
        valid_next = valid_reg;
        time_next  = time_reg;
        nid_next   = nid_reg;
        idx_next   = idx_reg;
        mode_next  = mode_reg;
        dly_next   = dly_reg;
        dst_next   = dst_reg;
        cid_next   = cid_reg;
        free_next  = free_reg;
        full_next  = full_reg;
        diff_next  = diff_reg;
        we         = 1'b0;
        waddr      = idx_reg;
        wdata      = rdata;
        dreq       = '0;
        push       = 1'b0;
        push_k     = KIND_TIMEOUT;
        push_id    = rdata.id;
        push_dst   = rdata.dest;
        push_cnt   = COUNT_W'(1);
        flush      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                idx_next = '0;
                if (s_valid) begin
                    mode_next = s_mode;
                    dly_next  = dly_fix;
                    dst_next  = s_dest_id;
                    cid_next  = s_cancel_id;
                    full_next = 1'b1;
                    free_next = '0;
                    for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
                        if (!valid_reg[i]) begin
                            full_next = 1'b0;
                            free_next = IDX_W'(i);
                        end
                    end
                    if (s_mode == MODE_ADVANCE) begin
                        time_next  = time_reg + TIME_W'(s_elapsed);
                        state_next = ST_READ;
                    end else if (s_mode == MODE_CANCEL) begin
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                push     = 1'b1;
                push_dst = '0;
                push_cnt = '0;
                if (full_reg) begin
                    push_k  = KIND_FULL;
                    push_id = '0;
                end else begin
                    push_k  = KIND_ID;
                    push_id = nid_reg;
                    we      = 1'b1;
                    waddr   = free_reg;
                    wdata.id        = nid_reg;
                    wdata.dest      = dst_reg;
                    wdata.deadline  = time_reg + TIME_W'(dly_reg);
                    wdata.period    = dly_reg;
                    wdata.repeating = (mode_reg == MODE_REPEAT);
                    valid_next[free_reg] = 1'b1;
                    nid_next = nid_reg + 1'b1;
                end
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                // waits until the output register is free for the pending start result; RAM write settles
                if (!pend_reg || out_free) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                diff_next = time_reg - rdata.deadline;
                if (!valid_reg[idx_reg]) begin
                    state_next = ST_EMIT;
                end else if (mode_reg == MODE_CANCEL) begin
                    if (rdata.id == cid_reg) begin
                        valid_next[idx_reg] = 1'b0;
                    end
                    state_next = ST_EMIT;
                end else if (diff_next[TIME_W-1]) begin
                    state_next = ST_EMIT;
                end else if (!rdata.repeating) begin
                    if (!pend_reg || out_free) begin
                        push = 1'b1;
                        valid_next[idx_reg] = 1'b0;
                        state_next = ST_EMIT;
                    end
                end else begin
                    dreq.start    = 1'b1;
                    dreq.dividend = diff_next[QUOT_W-1:0];
                    dreq.divisor  = rdata.period;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (drsp.done || (!drsp.busy && !dreq.start)) begin
                    if (!pend_reg || out_free) begin
                        push     = 1'b1;
                        push_cnt = (count_full > (QUOT_W+1)'(16'hFFFF)) ?
                                   COUNT_W'(16'hFFFF) : count_full[COUNT_W-1:0];
                        we       = 1'b1;
                        wdata.deadline = new_deadline;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                // step to the next slot, or finish
                if (idx_reg == IDX_W'(MAX_TIMERS - 1)) begin
                    if (!pend_reg) begin
                        state_next = ST_IDLE;
                    end else if (out_free) begin
                        flush      = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // pending slot and output register
    always_comb begin
        pend_next  = pend_reg;
        pk_next    = pk_reg;
        pid_next   = pid_reg;
        pdst_next  = pdst_reg;
        pcnt_next  = pcnt_reg;
        ov_next    = ov_reg && !m_ready;
        ok_next    = ok_reg;
        oid_next   = oid_reg;
        odst_next  = odst_reg;
        ocnt_next  = ocnt_reg;
        olast_next = olast_reg;
        if ((push || flush) && pend_reg) begin
            ov_next    = 1'b1;
            ok_next    = pk_reg;
            oid_next   = pid_reg;
            odst_next  = pdst_reg;
            ocnt_next  = pcnt_reg;
            olast_next = flush;
            pend_next  = 1'b0;
        end
        if (push) begin
            pend_next = 1'b1;
            pk_next   = push_k;
            pid_next  = push_id;
            pdst_next = push_dst;
            pcnt_next = push_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            time_reg  <= '0;
            nid_reg   <= '0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            time_reg  <= time_next;
            nid_reg   <= nid_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            ov_reg    <= ov_next;
        end
        mode_reg  <= mode_next;
        dly_reg   <= dly_next;
        dst_reg   <= dst_next;
        cid_reg   <= cid_next;
        free_reg  <= free_next;
        full_reg  <= full_next;
        diff_reg  <= diff_next;
        pk_reg    <= pk_next;
        pid_reg   <= pid_next;
        pdst_reg  <= pdst_next;
        pcnt_reg  <= pcnt_next;
        ok_reg    <= ok_next;
        oid_reg   <= oid_next;
        odst_reg  <= odst_next;
        ocnt_reg  <= ocnt_next;
        olast_reg <= olast_next;
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = ov_reg;
    assign m_kind          = ok_reg;
    assign m_timer_id      = oid_reg;
    assign m_notify_dest   = odst_reg;
    assign m_timeout_count = ocnt_reg;
    assign m_last          = olast_reg;

    // no result may be left pending once a new request is taken
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> !pend_reg)
        else $error("pending result at request accept");

    // the divider is only started from slot evaluation
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        dreq.start |-> (state_reg == ST_EVAL))
        else $error("divider started outside evaluation");

    // output holds while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_timer_id)))
        else $error("result dropped while stalled");

endmodule
